// ===== rtl/cpu8alu_pkg.sv =====
`timescale 1ns / 1ps

package cpu8alu_pkg;

  typedef enum logic [4:0] {
    OP_ADD    = 5'd0,
    OP_ADC    = 5'd1,
    OP_SUB    = 5'd2,
    OP_SBC    = 5'd3,
    OP_AND    = 5'd4,
    OP_XOR    = 5'd5,
    OP_OR     = 5'd6,
    OP_CP     = 5'd7,
    OP_INC    = 5'd8,
    OP_DEC    = 5'd9,
    OP_RL     = 5'd10,
    OP_RLC    = 5'd11,
    OP_RR     = 5'd12,
    OP_RRC    = 5'd13,
    OP_DAA    = 5'd14,
    OP_SCF    = 5'd15,
    OP_CCF    = 5'd16,
    OP_CPL    = 5'd17,
    OP_NOP    = 5'd18,
    OP_ADDKZ  = 5'd19,
    OP_ADCKZ  = 5'd20,
    OP_ADJUST = 5'd21,
    OP_SLA    = 5'd22,
    OP_SRA    = 5'd23,
    OP_SWAP   = 5'd24,
    OP_SRL    = 5'd25,
    OP_BIT    = 5'd26,
    OP_RES    = 5'd27,
    OP_SET    = 5'd28
  } op_t;

  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  localparam logic [7:0] DAA_LOW  = 8'h06;
  localparam logic [7:0] DAA_HIGH = 8'h60;
  localparam logic [7:0] DAA_MAX  = 8'h99;

endpackage

// ===== rtl/cpu_8bit_alu_with_flags_unit.sv =====
`timescale 1ns / 1ps

// 8-bit ALU with Z/N/H/C flags (bit3..bit0 of flags_in/flags_out). Each transaction
// carries one operation and returns exactly one result, in order. The operands are
// captured in an input register, the operation is decoded and evaluated by one level
// of combinational logic, and the result lands in an output register: out_valid rises
// when the input register hands its operation on to the output register, which waits while
// a result is stalled, and a new transaction is taken every cycle while the output side
// keeps up. A stalled result does not block the input register from filling. Opcodes
// 29 to 31 return zero and pass the flags through.

module cpu_8bit_alu_with_flags_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [4:0] opcode,
  input  logic [2:0] bit_index,
  input  logic [3:0] flags_in,
  input  logic [7:0] operand_a,
  input  logic [7:0] operand_b,
  input  logic       z_sign_high,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] result,
  output logic [3:0] flags_out
);

  logic       ex_valid;
  logic [4:0] ex_opcode;
  logic [2:0] ex_bit_index;
  logic [3:0] ex_flags;
  logic [7:0] ex_a;
  logic [7:0] ex_b;
  logic       ex_zs;

  logic       out_adv;
  logic [7:0] result_next;
  logic [3:0] flags_next;

  assign out_adv  = out_ready || !out_valid;
  assign in_ready = !ex_valid || out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (in_ready) begin
      ex_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ex_opcode    <= opcode;
      ex_bit_index <= bit_index;
      ex_flags     <= flags_in;
      ex_a         <= operand_a;
      ex_b         <= operand_b;
      ex_zs        <= z_sign_high;
    end
  end

  always_comb begin
    logic       c;
    logic       n;
    logic       cin;
    logic [8:0] sum;
    logic [4:0] hsum;
    logic [8:0] diff;
    logic [4:0] hdiff;
    logic [7:0] adj;
    logic       setc;
    logic [7:0] r;
    logic [3:0] f;

    c     = ex_flags[cpu8alu_pkg::FLAG_C];
    n     = ex_flags[cpu8alu_pkg::FLAG_N];
    cin   = c && (ex_opcode == cpu8alu_pkg::OP_ADC || ex_opcode == cpu8alu_pkg::OP_SBC ||
                  ex_opcode == cpu8alu_pkg::OP_ADCKZ);
    sum   = {1'b0, ex_a} + {1'b0, ex_b} + {8'd0, cin};
    hsum  = {1'b0, ex_a[3:0]} + {1'b0, ex_b[3:0]} + {4'd0, cin};
    diff  = {1'b0, ex_a} - {1'b0, ex_b} - {8'd0, cin};
    hdiff = {1'b0, ex_a[3:0]} - {1'b0, ex_b[3:0]} - {4'd0, cin};

    adj  = 8'd0;
    setc = 1'b0;
    if (ex_flags[cpu8alu_pkg::FLAG_H] || (!n && ex_b[3:0] > 4'd9)) begin
      adj = adj | cpu8alu_pkg::DAA_LOW;
    end
    if (c || (!n && ex_b > cpu8alu_pkg::DAA_MAX)) begin
      adj  = adj | cpu8alu_pkg::DAA_HIGH;
      setc = 1'b1;
    end

    r = 8'd0;
    f = ex_flags;
    case (ex_opcode)
      cpu8alu_pkg::OP_ADD, cpu8alu_pkg::OP_ADC: begin
        r = sum[7:0];
        f = {r == 8'd0, 1'b0, hsum[4], sum[8]};
      end
      cpu8alu_pkg::OP_SUB, cpu8alu_pkg::OP_SBC: begin
        r = diff[7:0];
        f = {r == 8'd0, 1'b1, hdiff[4], diff[8]};
      end
      cpu8alu_pkg::OP_CP: begin
        r = ex_a;
        f = {diff[7:0] == 8'd0, 1'b1, hdiff[4], diff[8]};
      end
      cpu8alu_pkg::OP_AND: begin
        r = ex_a & ex_b;
        f = {r == 8'd0, 3'b010};
      end
      cpu8alu_pkg::OP_XOR: begin
        r = ex_a ^ ex_b;
        f = {r == 8'd0, 3'b000};
      end
      cpu8alu_pkg::OP_OR: begin
        r = ex_a | ex_b;
        f = {r == 8'd0, 3'b000};
      end
      cpu8alu_pkg::OP_INC: begin
        r = ex_b + 8'd1;
        f = {r == 8'd0, 1'b0, ex_b[3:0] == 4'hF, c};
      end
      cpu8alu_pkg::OP_DEC: begin
        r = ex_b - 8'd1;
        f = {r == 8'd0, 1'b1, ex_b[3:0] == 4'h0, c};
      end
      cpu8alu_pkg::OP_RL: begin
        r = {ex_b[6:0], c};
        f = {r == 8'd0, 2'b00, ex_b[7]};
      end
      cpu8alu_pkg::OP_RLC: begin
        r = {ex_b[6:0], ex_b[7]};
        f = {r == 8'd0, 2'b00, ex_b[7]};
      end
      cpu8alu_pkg::OP_RR: begin
        r = {c, ex_b[7:1]};
        f = {r == 8'd0, 2'b00, ex_b[0]};
      end
      cpu8alu_pkg::OP_RRC: begin
        r = {ex_b[0], ex_b[7:1]};
        f = {r == 8'd0, 2'b00, ex_b[0]};
      end
      cpu8alu_pkg::OP_DAA: begin
        r = n ? (ex_b - adj) : (ex_b + adj);
        f = {r == 8'd0, n, 1'b0, setc};
      end
      cpu8alu_pkg::OP_SCF: begin
        r = ex_b;
        f = {ex_flags[cpu8alu_pkg::FLAG_Z], 3'b001};
      end
      cpu8alu_pkg::OP_CCF: begin
        r = ex_b;
        f = {ex_flags[cpu8alu_pkg::FLAG_Z], 2'b00, !c};
      end
      cpu8alu_pkg::OP_CPL: begin
        r = ~ex_b;
        f = {ex_flags[cpu8alu_pkg::FLAG_Z], 2'b11, c};
      end
      cpu8alu_pkg::OP_NOP: begin
        r = ex_b;
      end
      cpu8alu_pkg::OP_ADDKZ, cpu8alu_pkg::OP_ADCKZ: begin
        r = sum[7:0];
        f = {ex_flags[cpu8alu_pkg::FLAG_Z], 1'b0, hsum[4], sum[8]};
      end
      cpu8alu_pkg::OP_ADJUST: begin
        r = ex_b + {8{ex_zs}} + {7'd0, c};
        f = {2'b00, ex_flags[cpu8alu_pkg::FLAG_H], c};
      end
      cpu8alu_pkg::OP_SLA: begin
        r = {ex_b[6:0], 1'b0};
        f = {r == 8'd0, 2'b00, ex_b[7]};
      end
      cpu8alu_pkg::OP_SRA: begin
        r = {ex_b[7], ex_b[7:1]};
        f = {r == 8'd0, 2'b00, ex_b[0]};
      end
      cpu8alu_pkg::OP_SWAP: begin
        r = {ex_b[3:0], ex_b[7:4]};
        f = {r == 8'd0, 3'b000};
      end
      cpu8alu_pkg::OP_SRL: begin
        r = {1'b0, ex_b[7:1]};
        f = {r == 8'd0, 2'b00, ex_b[0]};
      end
      cpu8alu_pkg::OP_BIT: begin
        r = ex_b;
        f = {!ex_b[ex_bit_index], 2'b01, c};
      end
      cpu8alu_pkg::OP_RES: begin
        r = ex_b & ~(8'd1 << ex_bit_index);
      end
      cpu8alu_pkg::OP_SET: begin
        r = ex_b | (8'd1 << ex_bit_index);
      end
      default: begin
        r = 8'd0;
      end
    endcase

    result_next = r;
    flags_next  = f;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= ex_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_valid && out_adv) begin
      result    <= result_next;
      flags_out <= flags_next;
    end
  end

  // a free output side never holds off the input
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("in_ready low while output side is ready");

  // a pending operation moves to the output register when it can
  a_ex_to_out: assert property (@(posedge clk) disable iff (rst)
    (ex_valid && out_adv) |=> out_valid)
    else $error("pending operation lost on its way to the output");

  // nothing appears at the output without a pending operation
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (!ex_valid && out_valid && out_ready) |=> !out_valid)
    else $error("result shown without a pending operation");

  // input register only fills from an accepted transaction
  a_ex_fill: assert property (@(posedge clk) disable iff (rst)
    (!ex_valid && !in_valid) |=> !ex_valid)
    else $error("input register filled without a transaction");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> (!out_valid && !ex_valid))
    else $error("valid state not cleared by reset");

endmodule

// ===== sim/cpu_8bit_alu_with_flags_unit_test.sv =====
`timescale 1ns / 1ps

module cpu_8bit_alu_with_flags_unit_test;

  localparam logic [4:0] OP_UNUSED_LO = 5'd29;
  localparam logic [4:0] OP_UNUSED_HI = 5'd31;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_OPS = 1900;

  typedef struct packed {
    logic [7:0] result;
    logic [3:0] flags;
  } alu_out_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [4:0] opcode = '0;
  logic [2:0] bit_index = '0;
  logic [3:0] flags_in = '0;
  logic [7:0] operand_a = '0;
  logic [7:0] operand_b = '0;
  logic       z_sign_high = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] result;
  logic [3:0] flags_out;

  alu_out_t alu_expected[$];
  alu_out_t want;
  int       err_count = 0;
  int       cycle_count = 0;
  bit       calm = 1'b0;

  cpu_8bit_alu_with_flags_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .bit_index   (bit_index),
    .flags_in    (flags_in),
    .operand_a   (operand_a),
    .operand_b   (operand_b),
    .z_sign_high (z_sign_high),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result      (result),
    .flags_out   (flags_out)
  );

  always #5 clk = ~clk;

  function automatic alu_out_t alu_predict(logic [4:0] op, logic [2:0] bi, logic [3:0] fi,
                                           logic [7:0] a, logic [7:0] b, logic zs);
    logic [8:0] sum;
    logic [4:0] nib;
    logic [7:0] r;
    logic [3:0] f;
    logic [7:0] adj;
    logic       c;
    logic       cin;
    logic       n;
    logic       setc;
    alu_out_t   o;
    c = fi[cpu8alu_pkg::FLAG_C];
    n = fi[cpu8alu_pkg::FLAG_N];
    r = '0;
    f = fi;
    case (op)
      cpu8alu_pkg::OP_ADD, cpu8alu_pkg::OP_ADC,
      cpu8alu_pkg::OP_ADDKZ, cpu8alu_pkg::OP_ADCKZ: begin
        cin = (op == cpu8alu_pkg::OP_ADC || op == cpu8alu_pkg::OP_ADCKZ) ? c : 1'b0;
        sum = {1'b0, a} + {1'b0, b} + {8'b0, cin};
        nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cin};
        r = sum[7:0];
        if (op == cpu8alu_pkg::OP_ADDKZ || op == cpu8alu_pkg::OP_ADCKZ)
          f = {fi[cpu8alu_pkg::FLAG_Z], 1'b0, nib[4], sum[8]};
        else f = {r == 8'h00, 1'b0, nib[4], sum[8]};
      end
      cpu8alu_pkg::OP_SUB, cpu8alu_pkg::OP_SBC, cpu8alu_pkg::OP_CP: begin
        cin = (op == cpu8alu_pkg::OP_SBC) ? c : 1'b0;
        sum = {1'b0, a} - {1'b0, b} - {8'b0, cin};
        nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, cin};
        r = sum[7:0];
        f = {r == 8'h00, 1'b1, nib[4], sum[8]};
        if (op == cpu8alu_pkg::OP_CP) r = a;
      end
      cpu8alu_pkg::OP_AND: begin
        r = a & b;
        f = {r == 8'h00, 3'b010};
      end
      cpu8alu_pkg::OP_XOR: begin
        r = a ^ b;
        f = {r == 8'h00, 3'b000};
      end
      cpu8alu_pkg::OP_OR: begin
        r = a | b;
        f = {r == 8'h00, 3'b000};
      end
      cpu8alu_pkg::OP_INC: begin
        r = b + 8'h01;
        f = {r == 8'h00, 1'b0, b[3:0] == 4'hF, c};
      end
      cpu8alu_pkg::OP_DEC: begin
        r = b - 8'h01;
        f = {r == 8'h00, 1'b1, b[3:0] == 4'h0, c};
      end
      cpu8alu_pkg::OP_RL: begin
        r = {b[6:0], c};
        f = {r == 8'h00, 2'b00, b[7]};
      end
      cpu8alu_pkg::OP_RLC: begin
        r = {b[6:0], b[7]};
        f = {r == 8'h00, 2'b00, b[7]};
      end
      cpu8alu_pkg::OP_RR: begin
        r = {c, b[7:1]};
        f = {r == 8'h00, 2'b00, b[0]};
      end
      cpu8alu_pkg::OP_RRC: begin
        r = {b[0], b[7:1]};
        f = {r == 8'h00, 2'b00, b[0]};
      end
      cpu8alu_pkg::OP_DAA: begin
        adj = 8'h00;
        setc = 1'b0;
        if (fi[cpu8alu_pkg::FLAG_H] || (!n && b[3:0] > 4'h9)) adj = adj | cpu8alu_pkg::DAA_LOW;
        if (c || (!n && b > cpu8alu_pkg::DAA_MAX)) begin
          adj = adj | cpu8alu_pkg::DAA_HIGH;
          setc = 1'b1;
        end
        r = n ? b - adj : b + adj;
        f = {r == 8'h00, n, 1'b0, setc};
      end
      cpu8alu_pkg::OP_SCF: begin
        r = b;
        f = {fi[cpu8alu_pkg::FLAG_Z], 3'b001};
      end
      cpu8alu_pkg::OP_CCF: begin
        r = b;
        f = {fi[cpu8alu_pkg::FLAG_Z], 2'b00, ~c};
      end
      cpu8alu_pkg::OP_CPL: begin
        r = ~b;
        f = {fi[cpu8alu_pkg::FLAG_Z], 2'b11, c};
      end
      cpu8alu_pkg::OP_NOP: r = b;
      cpu8alu_pkg::OP_ADJUST: begin
        r = b + (zs ? 8'hFF : 8'h00) + {7'b0, c};
        f = {2'b00, fi[cpu8alu_pkg::FLAG_H], c};
      end
      cpu8alu_pkg::OP_SLA: begin
        r = {b[6:0], 1'b0};
        f = {r == 8'h00, 2'b00, b[7]};
      end
      cpu8alu_pkg::OP_SRA: begin
        r = {b[7], b[7:1]};
        f = {r == 8'h00, 2'b00, b[0]};
      end
      cpu8alu_pkg::OP_SWAP: begin
        r = {b[3:0], b[7:4]};
        f = {r == 8'h00, 3'b000};
      end
      cpu8alu_pkg::OP_SRL: begin
        r = {1'b0, b[7:1]};
        f = {r == 8'h00, 2'b00, b[0]};
      end
      cpu8alu_pkg::OP_BIT: begin
        r = b;
        f = {~b[bi], 2'b01, c};
      end
      cpu8alu_pkg::OP_RES: r = b & ~(8'h01 << bi);
      cpu8alu_pkg::OP_SET: r = b | (8'h01 << bi);
      default: r = 8'h00;
    endcase
    o.result = r;
    o.flags = f;
    return o;
  endfunction

  function automatic logic [7:0] pick_operand();
    logic [7:0] corners[8];
    corners = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h99, 8'h9A, 8'h80, 8'h01};
    if ($urandom_range(3, 0) == 0) return corners[$urandom_range(7, 0)];
    return 8'($urandom());
  endfunction

  // called just after a rising edge; returns at the edge where the transaction is taken
  task automatic send_op(logic [4:0] op, logic [2:0] bi, logic [3:0] fl,
                         logic [7:0] a, logic [7:0] b, logic zs);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(99, 0) < 3) begin
      gap = $urandom_range(3, 1);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    bit_index   <= bi;
    flags_in    <= fl;
    operand_a   <= a;
    operand_b   <= b;
    z_sign_high <= zs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    alu_expected.push_back(alu_predict(op, bi, fl, a, b, zs));
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (alu_expected.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic test_add_sub();
    send_op(cpu8alu_pkg::OP_ADD, 3'd0, 4'b0000, 8'hFF, 8'h01, 1'b0);
    send_op(cpu8alu_pkg::OP_ADC, 3'd0, 4'b0001, 8'h0F, 8'h00, 1'b0);
    send_op(cpu8alu_pkg::OP_SUB, 3'd0, 4'b0000, 8'h00, 8'h01, 1'b0);
    send_op(cpu8alu_pkg::OP_SBC, 3'd0, 4'b0001, 8'h10, 8'h0F, 1'b0);
    send_op(cpu8alu_pkg::OP_CP, 3'd0, 4'b1111, 8'h5A, 8'h5A, 1'b0);
    send_op(cpu8alu_pkg::OP_ADDKZ, 3'd0, 4'b1000, 8'h80, 8'h80, 1'b0);
    send_op(cpu8alu_pkg::OP_ADCKZ, 3'd0, 4'b0001, 8'hFF, 8'hFF, 1'b0);
  endtask

  task automatic test_logic();
    send_op(cpu8alu_pkg::OP_AND, 3'd0, 4'b1111, 8'hF0, 8'h0F, 1'b0);
    send_op(cpu8alu_pkg::OP_XOR, 3'd0, 4'b1111, 8'hFF, 8'hFF, 1'b0);
    send_op(cpu8alu_pkg::OP_OR, 3'd0, 4'b0000, 8'h80, 8'h01, 1'b0);
  endtask

  task automatic test_inc_dec();
    send_op(cpu8alu_pkg::OP_INC, 3'd0, 4'b0001, 8'h00, 8'hFF, 1'b0);
    send_op(cpu8alu_pkg::OP_DEC, 3'd0, 4'b0000, 8'hFF, 8'h00, 1'b0);
  endtask

  task automatic test_rotate_shift();
    send_op(cpu8alu_pkg::OP_RL, 3'd0, 4'b0001, 8'h00, 8'h80, 1'b0);
    send_op(cpu8alu_pkg::OP_RLC, 3'd0, 4'b0000, 8'h00, 8'h80, 1'b0);
    send_op(cpu8alu_pkg::OP_RR, 3'd0, 4'b0000, 8'h00, 8'h01, 1'b0);
    send_op(cpu8alu_pkg::OP_RRC, 3'd0, 4'b0001, 8'h00, 8'h00, 1'b0);
    send_op(cpu8alu_pkg::OP_SLA, 3'd0, 4'b1111, 8'h00, 8'h80, 1'b0);
    send_op(cpu8alu_pkg::OP_SRA, 3'd0, 4'b0000, 8'h00, 8'h81, 1'b0);
    send_op(cpu8alu_pkg::OP_SRL, 3'd0, 4'b0000, 8'h00, 8'h01, 1'b0);
    send_op(cpu8alu_pkg::OP_SWAP, 3'd0, 4'b1111, 8'h00, 8'hA5, 1'b0);
  endtask

  task automatic test_decimal_adjust();
    send_op(cpu8alu_pkg::OP_DAA, 3'd0, 4'b0000, 8'h00, 8'h9A, 1'b0);
    send_op(cpu8alu_pkg::OP_DAA, 3'd0, 4'b0111, 8'h00, 8'h66, 1'b0);
    send_op(cpu8alu_pkg::OP_DAA, 3'd0, 4'b1000, 8'h00, 8'h00, 1'b0);
  endtask

  task automatic test_flag_ops();
    send_op(cpu8alu_pkg::OP_SCF, 3'd0, 4'b1110, 8'h00, 8'h3C, 1'b0);
    send_op(cpu8alu_pkg::OP_CCF, 3'd0, 4'b0111, 8'h00, 8'hC3, 1'b0);
    send_op(cpu8alu_pkg::OP_CPL, 3'd0, 4'b1001, 8'h00, 8'h00, 1'b0);
    send_op(cpu8alu_pkg::OP_NOP, 3'd0, 4'b1010, 8'h00, 8'h55, 1'b0);
    send_op(cpu8alu_pkg::OP_ADJUST, 3'd0, 4'b1111, 8'h00, 8'h00, 1'b1);
    send_op(cpu8alu_pkg::OP_ADJUST, 3'd0, 4'b0101, 8'h00, 8'hFF, 1'b0);
  endtask

  task automatic test_bit_ops();
    send_op(cpu8alu_pkg::OP_BIT, 3'd7, 4'b0001, 8'h00, 8'h7F, 1'b0);
    send_op(cpu8alu_pkg::OP_RES, 3'd0, 4'b0110, 8'h00, 8'hFF, 1'b0);
    send_op(cpu8alu_pkg::OP_SET, 3'd7, 4'b1001, 8'h00, 8'h00, 1'b0);
  endtask

  task automatic test_undefined();
    send_op(OP_UNUSED_LO, 3'd7, 4'b1111, 8'hFF, 8'hFF, 1'b1);
    send_op(OP_UNUSED_HI, 3'd0, 4'b0101, 8'h12, 8'h34, 1'b0);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 3) wait_for_drain();
      calm = (i >= count / 2 && i < count / 2 + 300);
      send_op(5'($urandom_range(31, 0)), 3'($urandom_range(7, 0)),
              4'($urandom_range(15, 0)), pick_operand(), pick_operand(),
              1'($urandom_range(1, 0)));
    end
    calm = 1'b0;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= calm || ($urandom_range(99, 0) >= 6);
    end
  end

  // scoreboard: each transaction on the result side against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (alu_expected.size() == 0) begin
        $error("result transaction with nothing pending: result %h flags_out %h",
               result, flags_out);
        err_count++;
      end else begin
        want = alu_expected.pop_front();
        if (result !== want.result) begin
          $error("result: expected %h, got %h", want.result, result);
          err_count++;
        end
        if (flags_out !== want.flags) begin
          $error("flags_out: expected %b, got %b", want.flags, flags_out);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_add_sub();
    test_logic();
    test_inc_dec();
    test_rotate_shift();
    test_decimal_adjust();
    test_flag_ops();
    test_bit_ops();
    test_undefined();
    test_random(RANDOM_OPS);
    wait_for_drain();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cpu8alu_pkg.sv
rtl/cpu_8bit_alu_with_flags_unit.sv
sim/cpu_8bit_alu_with_flags_unit_test.sv
